FILE: rtl/hsv2rgb_pkg.sv
// shared widths, defaults and the hue sector codes of the hsv to rgb converter
// no dependencies
package hsv2rgb_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int HUE_W = 16;
  localparam int SV_W  = 17;
  localparam int CH_W  = 8;

  localparam logic [CH_W-1:0] CH_MAX = '1;

  // sextant of the color wheel, from the integer part of hue*6
  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_t;

endpackage

FILE: rtl/hsv2rgb_if.sv
// valid/ready channel interfaces for hsv items in and rgb items out
// depends on hsv2rgb_pkg for field widths
interface hsv2rgb_in_if;
  logic                           valid;
  logic                           ready;
  logic [hsv2rgb_pkg::HUE_W-1:0]  hue;
  logic [hsv2rgb_pkg::SV_W-1:0]   saturation;
  logic [hsv2rgb_pkg::SV_W-1:0]   brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsv2rgb_out_if;
  logic                           valid;
  logic                           ready;
  logic [hsv2rgb_pkg::CH_W-1:0]   red;
  logic [hsv2rgb_pkg::CH_W-1:0]   green;
  logic [hsv2rgb_pkg::CH_W-1:0]   blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: rtl/hsv_to_rgb_converter_top.sv
// hsv to rgb converter, five stage pipeline, one item per cycle while out_rgb is not stalled
// depends on hsv2rgb_pkg and the channel interfaces in hsv2rgb_if.sv
//
//  channel   direction  payload                          handshake
//  in_pix    sink       hue 16, saturation 17, bright 17 valid/ready
//  out_rgb   source     red 8, green 8, blue 8           valid/ready
//
// an accepted item moves through h6_r, the stage 2, 3 and 4 registers and ch_r to out_rgb
// one item enters every cycle unless out_rgb stalls; the rate is set by the product
// stages (f*s, then v*k per channel), each combinational and followed by a register
// reset (rst_n low, synchronous) clears the stage valid bits only
// a stall on out_rgb freezes the whole pipe; in_pix.ready drops only while
// the output register holds a result that is not taken
module hsv_to_rgb_converter_top #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  hsv2rgb_in_if.sink           in_pix,
  hsv2rgb_out_if.source        out_rgb
);

  // widths that follow from the fraction size
  localparam int KW = FRAC_BITS + 1;        // values 0..one
  localparam int HW = FRAC_BITS + 3;        // hue*6
  localparam int PW = 2 * KW;               // v*k
  localparam int XW = PW + 8;               // v*k*255
  localparam int RW = XW + 1 - 2 * FRAC_BITS;

  localparam logic [31:0]   ONE_L = 32'(1) << FRAC_BITS;
  localparam logic [KW-1:0] ONE_K = KW'(1) << FRAC_BITS;
  localparam logic [XW:0]   HALF  = (XW + 1)'(1) << (2 * FRAC_BITS - 1);

  // pipeline advances whenever the output register is free or being drained
  logic en;
  logic [4:0] vld_r;

  assign en           = !vld_r[4] || out_rgb.ready;
  assign in_pix.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_pix.valid};
    end
  end

  // stage 1: hue wrap, clamps, hue*6
  logic [FRAC_BITS-1:0] h_nxt;
  logic [KW-1:0]        s1_nxt, v1_nxt;
  logic [HW-1:0]        h6_r;
  logic [KW-1:0]        s1_r, v1_r;

  always_comb begin
    h_nxt  = FRAC_BITS'(32'(in_pix.hue) & (ONE_L - 32'd1));
    s1_nxt = (32'(in_pix.saturation) > ONE_L) ? ONE_K : KW'(in_pix.saturation);
    v1_nxt = (32'(in_pix.brightness) > ONE_L) ? ONE_K : KW'(in_pix.brightness);
  end

  // stage 2: split into sector and fraction, f*s
  hsv2rgb_pkg::sector_t sec_nxt, sec2_r;
  logic [FRAC_BITS-1:0] f_nxt;
  logic [FRAC_BITS+KW-1:0] fsp_nxt;
  logic [KW-1:0]        fs2_r, s2_r, v2_r;

  always_comb begin
    sec_nxt = hsv2rgb_pkg::sector_t'(h6_r[HW-1:FRAC_BITS]);
    f_nxt   = h6_r[FRAC_BITS-1:0];
    fsp_nxt = (FRAC_BITS + KW)'(f_nxt) * (FRAC_BITS + KW)'(s1_r);
  end

  // stage 3: channel factors and sector select
  logic [KW-1:0] kp, kq, kt;
  logic [KW-1:0] k_nxt [3];
  logic [KW-1:0] k3_r  [3];
  logic [KW-1:0] v3_r;

  always_comb begin
    kp = ONE_K - s2_r;
    kq = ONE_K - fs2_r;
    kt = ONE_K - s2_r + fs2_r;
    case (sec2_r)
      hsv2rgb_pkg::SEC_RED_YELLOW: begin
        k_nxt[0] = ONE_K; k_nxt[1] = kt;    k_nxt[2] = kp;
      end
      hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
        k_nxt[0] = kq;    k_nxt[1] = ONE_K; k_nxt[2] = kp;
      end
      hsv2rgb_pkg::SEC_GREEN_CYAN: begin
        k_nxt[0] = kp;    k_nxt[1] = ONE_K; k_nxt[2] = kt;
      end
      hsv2rgb_pkg::SEC_CYAN_BLUE: begin
        k_nxt[0] = kp;    k_nxt[1] = kq;    k_nxt[2] = ONE_K;
      end
      hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
        k_nxt[0] = kt;    k_nxt[1] = kp;    k_nxt[2] = ONE_K;
      end
      default: begin
        k_nxt[0] = ONE_K; k_nxt[1] = kp;    k_nxt[2] = kq;
      end
    endcase
  end

  // stage 4: v*k per channel
  logic [PW-1:0] prod4_r [3];

  // stage 5: *255, round half up, saturate
  logic [XW-1:0]    x_c   [3];
  logic [XW:0]      sum_c [3];
  logic [RW-1:0]    r_c   [3];
  logic [hsv2rgb_pkg::CH_W-1:0] ch_nxt [3];
  logic [hsv2rgb_pkg::CH_W-1:0] ch_r   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x_c[i]   = (XW'(prod4_r[i]) << 8) - XW'(prod4_r[i]);
      sum_c[i] = (XW + 1)'(x_c[i]) + HALF;
      r_c[i]   = RW'(sum_c[i] >> (2 * FRAC_BITS));
      ch_nxt[i] = (r_c[i] > RW'(hsv2rgb_pkg::CH_MAX)) ? hsv2rgb_pkg::CH_MAX
                                                       : r_c[i][hsv2rgb_pkg::CH_W-1:0];
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (en) begin
      h6_r   <= HW'(h_nxt) * HW'(6);
      s1_r   <= s1_nxt;
      v1_r   <= v1_nxt;

      sec2_r <= sec_nxt;
      fs2_r  <= KW'(fsp_nxt >> FRAC_BITS);
      s2_r   <= s1_r;
      v2_r   <= v1_r;

      k3_r   <= k_nxt;
      v3_r   <= v2_r;

      for (int i = 0; i < 3; i++) begin
        prod4_r[i] <= PW'(v3_r) * PW'(k3_r[i]);
      end

      ch_r   <= ch_nxt;
    end
  end

  assign out_rgb.valid = vld_r[4];
  assign out_rgb.red   = ch_r[0];
  assign out_rgb.green = ch_r[1];
  assign out_rgb.blue  = ch_r[2];

endmodule

FILE: sim/tb_hsv_to_rgb_converter_top.sv
// testbench for hsv_to_rgb_converter_top: drives hsv items with random gaps and
// checks every rgb item against a bit-exact fixed-point conversion in a scoreboard
// depends on hsv2rgb_pkg, the channel interfaces and the converter top level
module tb_hsv_to_rgb_converter_top;
  import hsv2rgb_pkg::*;

  localparam int FB          = FRAC_BITS_DEF;
  localparam int IDLE_LIMIT  = 2000;   // cycles with no handshake before giving up
  localparam int PIPE_DEPTH  = 5;      // accepted item to result
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off
  localparam int HOLD_AT     = 400;    // results seen before the hold-off starts

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // expected rgb items in order, each computed when its hsv item is accepted
  class rgb_scoreboard;
    rgb_t expected_rgb[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    // one channel: v*k*255 rounded half up, limited to full scale
    function logic [CH_W-1:0] to_channel(logic [63:0] v, logic [63:0] k);
      logic [63:0] prod;
      logic [63:0] r;
      prod = v * k * 64'd255;
      r = (prod + (64'd1 << (2 * FB - 1))) >> (2 * FB);
      if (r > 64'(CH_MAX)) r = 64'(CH_MAX);
      return r[CH_W-1:0];
    endfunction

    function rgb_t hsv_to_rgb(logic [HUE_W-1:0] hue, logic [SV_W-1:0] sat,
                              logic [SV_W-1:0] bright);
      logic [63:0] one, s, v, h6, sh, f, fs, kp, kq, kt, rk, gk, bk;
      sector_t sec;
      rgb_t res;
      one = 64'd1 << FB;
      s = 64'(sat);
      v = 64'(bright);
      if (s > one) s = one;
      if (v > one) v = one;
      // hue is a fraction of a turn, so only the low FB bits count
      h6 = (64'(hue) & (one - 64'd1)) * 64'd6;
      sh = h6 >> FB;
      sec = sector_t'(sh[2:0]);
      f = h6 & (one - 64'd1);
      fs = (f * s) >> FB;
      kp = one - s;
      kq = one - fs;
      kt = one - s + fs;
      case (sec)
        SEC_RED_YELLOW: begin
          rk = one; gk = kt; bk = kp;
        end
        SEC_YELLOW_GREEN: begin
          rk = kq; gk = one; bk = kp;
        end
        SEC_GREEN_CYAN: begin
          rk = kp; gk = one; bk = kt;
        end
        SEC_CYAN_BLUE: begin
          rk = kp; gk = kq; bk = one;
        end
        SEC_BLUE_MAGENTA: begin
          rk = kt; gk = kp; bk = one;
        end
        default: begin
          rk = one; gk = kp; bk = kq;
        end
      endcase
      res.red   = to_channel(v, rk);
      res.green = to_channel(v, gk);
      res.blue  = to_channel(v, bk);
      return res;
    endfunction

    function void note_pixel(logic [HUE_W-1:0] hue, logic [SV_W-1:0] sat,
                             logic [SV_W-1:0] bright);
      expected_rgb.push_back(hsv_to_rgb(hue, sat, bright));
    endfunction

    function void check_rgb(logic [CH_W-1:0] red, logic [CH_W-1:0] green,
                            logic [CH_W-1:0] blue);
      rgb_t exp_rgb;
      if (expected_rgb.size() == 0) begin
        $error("rgb item with no hsv item waiting: %0d %0d %0d", red, green, blue);
        errors++;
        return;
      end
      exp_rgb = expected_rgb.pop_front();
      if (red !== exp_rgb.red) begin
        $error("red: expected %0d, got %0d", exp_rgb.red, red);
        errors++;
      end
      if (green !== exp_rgb.green) begin
        $error("green: expected %0d, got %0d", exp_rgb.green, green);
        errors++;
      end
      if (blue !== exp_rgb.blue) begin
        $error("blue: expected %0d, got %0d", exp_rgb.blue, blue);
        errors++;
      end
    endfunction

    function int pending();
      return expected_rgb.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  hsv2rgb_in_if  in_pix();
  hsv2rgb_out_if out_rgb();

  hsv_to_rgb_converter_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_rgb (out_rgb)
  );

  rgb_scoreboard sb;
  int            rgb_seen;     // results taken so far, steers the hold-off
  bit            send_burst;   // sender stretch with no gaps
  bit            recv_burst;   // receiver stretch with no stalls

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one hsv item after a random gap and wait for the handshake;
  // valid is only ever written once per edge, so back-to-back items keep it high
  task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [SV_W-1:0] sat,
                            input logic [SV_W-1:0] bright);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_pix.valid      <= 1'b1;
    in_pix.hue        <= hue;
    in_pix.saturation <= sat;
    in_pix.brightness <= bright;
    do @(posedge clk); while (!in_pix.ready);
    sb.note_pixel(hue, sat, bright);
  endtask

  // hold the input quiet until every result in flight has come back
  task automatic drain_results();
    in_pix.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // saturation and brightness: mostly in range, with the clamp edges and
  // the over-one region hit often enough
  function automatic logic [SV_W-1:0] pick_level();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return '0;
      1:       return SV_W'(1 << FB);
      2, 3:    return SV_W'($urandom_range(0, (1 << SV_W) - 1));
      default: return SV_W'($urandom_range(0, 1 << FB));
    endcase
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      // new stretch every 50 items, a quarter of them without gaps
      if (i % 50 == 0) send_burst = ($urandom_range(0, 3) == 0);
      send_pixel(HUE_W'($urandom_range(0, (1 << HUE_W) - 1)), pick_level(), pick_level());
    end
  endtask

  initial begin
    sb = new();
    send_burst = 1'b0;
    rst_n             <= 1'b0;
    in_pix.valid      <= 1'b0;
    in_pix.hue        <= '0;
    in_pix.saturation <= '0;
    in_pix.brightness <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: hue extremes and both sides of each sector boundary
    send_pixel(16'd0,     17'd65536,  17'd65536);
    send_pixel(16'd65535, 17'd65536,  17'd65536);
    send_pixel(16'd10922, 17'd65536,  17'd65536);
    send_pixel(16'd10923, 17'd65536,  17'd65536);
    send_pixel(16'd21845, 17'd65536,  17'd65536);
    send_pixel(16'd21846, 17'd65536,  17'd65536);
    send_pixel(16'd32767, 17'd65536,  17'd65536);
    send_pixel(16'd32768, 17'd65536,  17'd65536);
    send_pixel(16'd43690, 17'd65536,  17'd65536);
    send_pixel(16'd43691, 17'd65536,  17'd65536);
    send_pixel(16'd54613, 17'd65536,  17'd65536);
    send_pixel(16'd54614, 17'd65536,  17'd65536);
    // gray axis, black, and the smallest nonzero brightness
    send_pixel(16'd12345, 17'd0,      17'd65536);
    send_pixel(16'd40000, 17'd32768,  17'd0);
    send_pixel(16'd5000,  17'd65536,  17'd1);
    // saturation above one clamps
    send_pixel(16'd20000, 17'd65537,  17'd65536);
    send_pixel(16'd50000, 17'd131071, 17'd40000);
    // brightness above one clamps
    send_pixel(16'd30000, 17'd30000,  17'd65537);
    send_pixel(16'd60000, 17'd50000,  17'd131071);
    // both fields at their maximum codes
    send_pixel(16'd65535, 17'd131071, 17'd131071);
    send_pixel(16'd0,     17'd131071, 17'd131071);
    // half scale everywhere, a likely rounding tie region
    send_pixel(16'd32768, 17'd32768,  17'd32768);
    send_pixel(16'd1,     17'd1,      17'd65535);
    drain_results();

    send_random(700);
    // sender pauses here until the pipe is empty
    drain_results();
    send_random(850);
    drain_results();

    // let anything stray fall out of the pipe before judging
    repeat (4 * PIPE_DEPTH) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver side
  // ---------------------------------------------------------------------------

  // ready stalls at random per item; once, a long hold-off lets the pipe fill
  // while the sender keeps offering, so in_pix.ready has to drop
  initial begin
    int  stall;
    bit  held;
    rgb_seen = 0;
    held = 1'b0;
    recv_burst = 1'b0;
    out_rgb.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rgb_seen % 40 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      stall = recv_burst ? 0 : $urandom_range(0, 7);
      if (!held && rgb_seen >= HOLD_AT) begin
        stall = HOLD_CYCLES;
        held = 1'b1;
      end
      if (stall > 0) begin
        out_rgb.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_rgb.ready <= 1'b1;
      do @(posedge clk); while (!out_rgb.valid);
      sb.check_rgb(out_rgb.red, out_rgb.green, out_rgb.blue);
      rgb_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any handshake on either channel
  // ---------------------------------------------------------------------------
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_pix.valid && in_pix.ready) || (out_rgb.valid && out_rgb.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule
